>>> hw/rtl/ibwt_pkg.sv
// Shared types and constants for the inverse BWT decoder.
package ibwt_pkg;

  localparam int MAX_BLOCK = 4096;
  localparam int ADDR_W    = $clog2(MAX_BLOCK);
  localparam int CNT_W     = ADDR_W + 1;
  localparam int HDR_BYTES = 4;
  localparam int SYMBOLS   = 256;
  localparam int Q_DEPTH   = 4;
  localparam int Q_PTR_W   = 2;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_FETCH = 1'b1;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_INDEX     = 3'd1;
  localparam logic [2:0] ST_LONG      = 3'd2;
  localparam logic [2:0] ST_SHORT     = 3'd3;
  localparam logic [2:0] ST_NOT_READY = 3'd4;

  typedef enum logic [1:0] {
    PH_LOADING,
    PH_READY,
    PH_FAILED
  } phase_t;

  typedef enum logic [1:0] {
    OP_STORE,
    OP_WALK,
    OP_LASTBYTE,
    OP_STATUS
  } op_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_ST_A,
    BK_ST_B,
    BK_PRE,
    BK_SC_A,
    BK_SC_B,
    BK_SC_C,
    BK_WK_A,
    BK_WK_B,
    BK_LB_A,
    BK_LB_B,
    BK_STAT
  } back_state_t;

  typedef struct packed {
    logic       cmd;
    logic [7:0] data_byte;
    logic       last_in;
  } req_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
    logic [2:0] status;
  } rsp_t;

  // one queued operation for the back end
  typedef struct packed {
    op_t              op;
    logic [7:0]       data;
    logic [ADDR_W-1:0] addr;
    logic [ADDR_W-1:0] prow;
    logic [CNT_W-1:0] len;
    logic [2:0]       status;
    logic             clear;
    logic             build;
  } op_entry_t;

endpackage

>>> hw/rtl/inverse_bwt_decoder.sv
// Top level of the inverse BWT decoder.
// Load transactions (cmd 0) carry a 4-byte big-endian primary index and then the
// last column, last_in on the final byte; fetch transactions (cmd 1) each return
// one result one cycle wide on rsp_valid/rsp, which must be taken when shown.
// A 4-entry op queue sits between the transaction decoder and the memory engine;
// busy is high only while that queue is full. The engine does a count
// read-modify-write per body byte, a memory read then a register per decoding
// fetch, a register of the status per fetch that only reports a status, and
// after the final good byte a sort (one pass over the 256 symbol counts, then
// one byte at a time through the count memory). Fetches queued during the sort
// wait behind it; results come out in transaction order.
module inverse_bwt_decoder (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  ibwt_pkg::req_t  req,
  output logic            rsp_valid,
  output ibwt_pkg::rsp_t  rsp
);

  logic                accept;
  logic                push, pop, q_empty, q_full;
  ibwt_pkg::op_entry_t push_op, q_head;

  assign busy   = q_full;
  assign accept = start && !busy;

  ibwt_front u_front (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .req     (req),
    .push    (push),
    .push_op (push_op)
  );

  ibwt_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_op (push_op),
    .pop     (pop),
    .head    (q_head),
    .empty   (q_empty),
    .full    (q_full)
  );

  ibwt_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .pop       (pop),
    .rsp_valid (rsp_valid),
    .rsp       (rsp)
  );

endmodule

>>> hw/rtl/ibwt_front.sv
// Front end: tracks header, length, phase and errors; queues an op per fetch and stored body byte.
module ibwt_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  ibwt_pkg::req_t      req,
  output logic                push,
  output ibwt_pkg::op_entry_t push_op
);

  ibwt_pkg::phase_t              phase, phase_next;
  logic [2:0]                    hdr, hdr_next;
  logic [ibwt_pkg::CNT_W-1:0]    bcnt, bcnt_next;
  logic [31:0]                   prow, prow_next;
  logic [ibwt_pkg::CNT_W-1:0]    emitted, emitted_next;
  logic [2:0]                    err, err_next;

  always_comb begin
    phase_next   = phase;
    hdr_next     = hdr;
    bcnt_next    = bcnt;
    prow_next    = prow;
    emitted_next = emitted;
    err_next     = err;
    push         = 1'b0;
    push_op      = '0;
    push_op.op   = ibwt_pkg::OP_STATUS;
    if (accept) begin
      if (req.cmd == ibwt_pkg::CMD_LOAD) begin
        if (phase != ibwt_pkg::PH_LOADING) begin
          phase_next   = ibwt_pkg::PH_LOADING;
          hdr_next     = '0;
          bcnt_next    = '0;
          prow_next    = '0;
          emitted_next = '0;
          err_next     = ibwt_pkg::ST_OK;
        end
        if (hdr_next < 3'(ibwt_pkg::HDR_BYTES)) begin
          prow_next = {prow_next[23:0], req.data_byte};
          hdr_next  = hdr_next + 3'd1;
        end else if (bcnt_next < ibwt_pkg::CNT_W'(ibwt_pkg::MAX_BLOCK)) begin
          push         = 1'b1;
          push_op.op   = ibwt_pkg::OP_STORE;
          push_op.data = req.data_byte;
          push_op.addr = bcnt_next[ibwt_pkg::ADDR_W-1:0];
          push_op.clear = (bcnt_next == '0);
          bcnt_next    = bcnt_next + 1'b1;
        end else begin
          err_next = ibwt_pkg::ST_LONG;
        end
        if (req.last_in) begin
          if (err_next == ibwt_pkg::ST_OK) begin
            if (hdr_next < 3'(ibwt_pkg::HDR_BYTES) || bcnt_next == '0)
              err_next = ibwt_pkg::ST_SHORT;
            else if (prow_next >= 32'(bcnt_next))
              err_next = ibwt_pkg::ST_INDEX;
          end
          if (err_next != ibwt_pkg::ST_OK) begin
            phase_next = ibwt_pkg::PH_FAILED;
          end else begin
            // a good block always ends on a stored body byte
            push_op.build = 1'b1;
            push_op.len   = bcnt_next;
            push_op.prow  = prow_next[ibwt_pkg::ADDR_W-1:0];
            emitted_next  = '0;
            phase_next    = ibwt_pkg::PH_READY;
          end
        end
      end else begin
        push = 1'b1;
        if (phase == ibwt_pkg::PH_FAILED) begin
          push_op.status = err;
        end else if (phase != ibwt_pkg::PH_READY) begin
          push_op.status = ibwt_pkg::ST_NOT_READY;
        end else if (emitted + 1'b1 < bcnt) begin
          push_op.op   = ibwt_pkg::OP_WALK;
          emitted_next = emitted + 1'b1;
        end else begin
          push_op.op   = ibwt_pkg::OP_LASTBYTE;
          push_op.prow = prow[ibwt_pkg::ADDR_W-1:0];
          phase_next   = ibwt_pkg::PH_LOADING;
          hdr_next     = '0;
          bcnt_next    = '0;
          prow_next    = '0;
          emitted_next = '0;
          err_next     = ibwt_pkg::ST_OK;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= ibwt_pkg::PH_LOADING;
      hdr     <= '0;
      bcnt    <= '0;
      prow    <= '0;
      emitted <= '0;
      err     <= ibwt_pkg::ST_OK;
    end else begin
      phase   <= phase_next;
      hdr     <= hdr_next;
      bcnt    <= bcnt_next;
      prow    <= prow_next;
      emitted <= emitted_next;
      err     <= err_next;
    end
  end

endmodule

>>> hw/rtl/ibwt_queue.sv
// Small FIFO of ops between front and back end.
module ibwt_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  ibwt_pkg::op_entry_t push_op,
  input  logic                pop,
  output ibwt_pkg::op_entry_t head,
  output logic                empty,
  output logic                full
);

  ibwt_pkg::op_entry_t              slots [ibwt_pkg::Q_DEPTH];
  logic [ibwt_pkg::Q_PTR_W-1:0]     wr_ptr, rd_ptr;
  logic [ibwt_pkg::Q_PTR_W:0]       fill;

  assign empty = (fill == '0);
  assign full  = (fill == (ibwt_pkg::Q_PTR_W+1)'(ibwt_pkg::Q_DEPTH));
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_op;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      fill <= fill + (ibwt_pkg::Q_PTR_W+1)'(push) - (ibwt_pkg::Q_PTR_W+1)'(pop);
    end
  end

endmodule

>>> hw/rtl/ibwt_back.sv
// Back end: column memories, counting sort and the decode walk.
module ibwt_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_empty,
  input  ibwt_pkg::op_entry_t q_head,
  output logic                pop,
  output logic                rsp_valid,
  output ibwt_pkg::rsp_t      rsp
);

  localparam int AW = ibwt_pkg::ADDR_W;
  localparam int CW = ibwt_pkg::CNT_W;

  ibwt_pkg::back_state_t state, state_next;
  ibwt_pkg::op_entry_t   cur;

  logic [7:0]    lmem    [ibwt_pkg::MAX_BLOCK];
  logic [7:0]    fmem    [ibwt_pkg::MAX_BLOCK];
  logic [AW-1:0] linkmem [ibwt_pkg::MAX_BLOCK];
  logic [CW-1:0] cntmem  [ibwt_pkg::SYMBOLS];
  logic [ibwt_pkg::SYMBOLS-1:0] cnt_valid;

  logic [7:0]    l_rd, f_rd;
  logic [AW-1:0] link_rd;
  logic [CW-1:0] cnt_rd;

  logic [AW-1:0] walk_row;
  logic [8:0]    sym;
  logic [CW-1:0] sum;
  logic [CW-1:0] idx;
  logic [7:0]    bsel;

  // datapath controls
  logic          l_we, f_we, c_we;
  logic [AW-1:0] l_waddr, l_raddr, f_waddr, f_raddr;
  logic [7:0]    c_waddr, c_raddr;
  logic [CW-1:0] c_wdata;
  logic [7:0]    c_raddr_q;

  always_comb begin
    state_next = state;
    unique case (state)
      ibwt_pkg::BK_IDLE: begin
        if (!q_empty) begin
          unique case (q_head.op)
            ibwt_pkg::OP_STORE:    state_next = ibwt_pkg::BK_ST_A;
            ibwt_pkg::OP_WALK:     state_next = ibwt_pkg::BK_WK_A;
            ibwt_pkg::OP_LASTBYTE: state_next = ibwt_pkg::BK_LB_A;
            ibwt_pkg::OP_STATUS:   state_next = ibwt_pkg::BK_STAT;
            default:               state_next = ibwt_pkg::BK_IDLE;
          endcase
        end
      end
      ibwt_pkg::BK_ST_A: state_next = ibwt_pkg::BK_ST_B;
      ibwt_pkg::BK_ST_B: state_next = cur.build ? ibwt_pkg::BK_PRE : ibwt_pkg::BK_IDLE;
      ibwt_pkg::BK_PRE:
        if (sym == 9'(ibwt_pkg::SYMBOLS)) state_next = ibwt_pkg::BK_SC_A;
      ibwt_pkg::BK_SC_A: state_next = ibwt_pkg::BK_SC_B;
      ibwt_pkg::BK_SC_B: state_next = ibwt_pkg::BK_SC_C;
      ibwt_pkg::BK_SC_C:
        state_next = (idx + 1'b1 == cur.len) ? ibwt_pkg::BK_IDLE : ibwt_pkg::BK_SC_A;
      ibwt_pkg::BK_WK_A: state_next = ibwt_pkg::BK_WK_B;
      ibwt_pkg::BK_WK_B: state_next = ibwt_pkg::BK_IDLE;
      ibwt_pkg::BK_LB_A: state_next = ibwt_pkg::BK_LB_B;
      ibwt_pkg::BK_LB_B: state_next = ibwt_pkg::BK_IDLE;
      ibwt_pkg::BK_STAT: state_next = ibwt_pkg::BK_IDLE;
      default:           state_next = ibwt_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    pop     = (state == ibwt_pkg::BK_IDLE) && !q_empty;
    l_we    = (state == ibwt_pkg::BK_ST_A);
    l_waddr = cur.addr;
    l_raddr = (state == ibwt_pkg::BK_LB_A) ? cur.prow : idx[AW-1:0];
    f_we    = (state == ibwt_pkg::BK_SC_C);
    f_waddr = cnt_rd[AW-1:0];
    f_raddr = walk_row;
    c_we    = 1'b0;
    c_waddr = cur.data;
    c_wdata = '0;
    c_raddr = cur.data;
    unique case (state)
      ibwt_pkg::BK_ST_B: begin
        c_we    = 1'b1;
        c_wdata = (cnt_valid[cur.data] ? cnt_rd : '0) + 1'b1;
      end
      ibwt_pkg::BK_PRE: begin
        c_raddr = sym[7:0];
        c_waddr = c_raddr_q;
        c_we    = (sym != '0);
        c_wdata = sum;
      end
      ibwt_pkg::BK_SC_B: c_raddr = l_rd;
      ibwt_pkg::BK_SC_C: begin
        c_we    = 1'b1;
        c_waddr = bsel;
        c_wdata = cnt_rd + 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (l_we) lmem[l_waddr] <= cur.data;
    l_rd <= lmem[l_raddr];
    if (f_we) begin
      fmem[f_waddr]    <= bsel;
      linkmem[f_waddr] <= idx[AW-1:0];
    end
    f_rd    <= fmem[f_raddr];
    link_rd <= linkmem[f_raddr];
    if (c_we) cntmem[c_waddr] <= c_wdata;
    cnt_rd    <= cntmem[c_raddr];
    c_raddr_q <= c_raddr;
  end

  always_ff @(posedge clk) begin
    if (pop) cur <= q_head;
    unique case (state)
      ibwt_pkg::BK_ST_B: begin
        walk_row <= cur.prow;
        sym      <= '0;
        sum      <= '0;
        idx      <= '0;
      end
      ibwt_pkg::BK_PRE: begin
        sym <= sym + 1'b1;
        if (sym != '0) sum <= sum + (cnt_valid[c_raddr_q] ? cnt_rd : '0);
      end
      ibwt_pkg::BK_SC_B: bsel <= l_rd;
      ibwt_pkg::BK_SC_C: idx <= idx + 1'b1;
      ibwt_pkg::BK_WK_B: walk_row <= link_rd;
      default: ;
    endcase
    unique case (state)
      ibwt_pkg::BK_WK_B: rsp <= {f_rd, 1'b0, ibwt_pkg::ST_OK};
      ibwt_pkg::BK_LB_B: rsp <= {l_rd, 1'b1, ibwt_pkg::ST_OK};
      ibwt_pkg::BK_STAT: rsp <= {8'h00, 1'b0, cur.status};
      default:           rsp <= '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ibwt_pkg::BK_IDLE;
      rsp_valid <= 1'b0;
      cnt_valid <= '0;
    end else begin
      state     <= state_next;
      rsp_valid <= (state == ibwt_pkg::BK_WK_B) || (state == ibwt_pkg::BK_LB_B)
                   || (state == ibwt_pkg::BK_STAT);
      if (state == ibwt_pkg::BK_ST_A && cur.clear) cnt_valid <= '0;
      if (state == ibwt_pkg::BK_ST_B) cnt_valid[cur.data] <= 1'b1;
      // prefix pass turns counts into start offsets
      if (state == ibwt_pkg::BK_PRE && sym != '0) cnt_valid[c_raddr_q] <= 1'b1;
    end
  end

endmodule
